// ----- rtl/clft_pkg.sv -----
// ----------------------------------------------------------------------------
// clft_pkg: shared types and constants of the command line field tokenizer
// Character class bounds, field limits, state and result records.
// ----------------------------------------------------------------------------
package clft_pkg;

  localparam int MAX_FIELD_SLOTS = 6;
  localparam int LINE_MAX        = 128;

  localparam int IDX_W = $clog2(MAX_FIELD_SLOTS + 1);
  localparam int POS_W = $clog2(LINE_MAX);
  localparam int VAL_W = 32;

  localparam logic [IDX_W-1:0] FIELD_LIMIT = IDX_W'(MAX_FIELD_SLOTS);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(LINE_MAX - 1);

  // exclusive bounds of the ASCII digit and letter ranges
  localparam logic [7:0] DIGIT_LO = 8'd47;
  localparam logic [7:0] DIGIT_HI = 8'd58;
  localparam logic [7:0] UPPER_LO = 8'd64;
  localparam logic [7:0] UPPER_HI = 8'd91;
  localparam logic [7:0] LOWER_LO = 8'd96;
  localparam logic [7:0] LOWER_HI = 8'd123;
  localparam logic [7:0] CHAR_EOL = 8'd0;

  // field type codes
  localparam logic TYPE_NUMERIC = 1'b0;
  localparam logic TYPE_ALPHA   = 1'b1;

  typedef struct packed {
    logic             after_delim;
    logic [IDX_W-1:0] fields_rec;
    logic [POS_W-1:0] char_pos;
    logic             in_field;
    logic             cur_numeric;
    logic [VAL_W-1:0] value_acc;
    logic             value_inv;
  } clft_state_t;

  typedef struct packed {
    logic [7:0]       out_char;
    logic             field_start;
    logic             start_type;
    logic [IDX_W-1:0] start_index;
    logic [POS_W-1:0] start_position;
    logic             field_end;
    logic [IDX_W-1:0] end_index;
    logic [VAL_W-1:0] end_value;
    logic             line_done;
    logic [IDX_W-1:0] field_count;
  } clft_result_t;

  localparam clft_state_t STATE_RESET = '{
    after_delim: 1'b1,
    fields_rec:  '0,
    char_pos:    '0,
    in_field:    1'b0,
    cur_numeric: 1'b0,
    value_acc:   '0,
    value_inv:   1'b0
  };

endpackage

// ----- rtl/clft_step.sv -----
// ----------------------------------------------------------------------------
// clft_step: per-character tokenizer logic
// Classifies one character and computes the next line state and the result.
// ----------------------------------------------------------------------------
module clft_step import clft_pkg::*; (
  input  logic [7:0]   ch,
  input  clft_state_t  st,
  output clft_state_t  st_nxt,
  output clft_result_t res
);

  logic             is_digit;
  logic             is_letter;
  logic             in_field_w;
  logic             numeric_w;
  logic             invalid_w;
  logic [VAL_W-1:0] acc_w;
  logic             done;
  clft_state_t      adv;

  // classify the character
  assign is_digit  = (ch > DIGIT_LO) && (ch < DIGIT_HI);
  assign is_letter = ((ch > UPPER_LO) && (ch < UPPER_HI)) ||
                     ((ch > LOWER_LO) && (ch < LOWER_HI));

  always_comb begin
    adv        = st;
    res        = '0;
    done       = 1'b0;
    in_field_w = st.in_field;
    numeric_w  = st.cur_numeric;
    invalid_w  = st.value_inv;
    acc_w      = st.value_acc;

    if (!(is_digit || is_letter)) begin
      // delimiter or end of line: close a recorded field
      if (st.in_field) begin
        res.field_end = 1'b1;
        res.end_index = st.fields_rec - IDX_W'(1);
        res.end_value = (st.cur_numeric && !st.value_inv) ? st.value_acc : '0;
      end
      adv.in_field    = 1'b0;
      adv.after_delim = 1'b1;
      done            = (ch == CHAR_EOL);
    end else begin
      res.out_char = ch;
      // open a field on the first field character after a delimiter
      if (st.after_delim) begin
        adv.after_delim = 1'b0;
        in_field_w      = 1'b0;
        if (st.fields_rec < FIELD_LIMIT) begin
          res.field_start    = 1'b1;
          res.start_type     = is_digit ? TYPE_NUMERIC : TYPE_ALPHA;
          res.start_index    = st.fields_rec;
          res.start_position = st.char_pos;
          adv.fields_rec     = st.fields_rec + IDX_W'(1);
          in_field_w         = 1'b1;
          numeric_w          = is_digit;
          acc_w              = '0;
          invalid_w          = 1'b0;
        end
      end
      // accumulate decimal value: acc * 10 + digit, wrapping
      if (in_field_w && numeric_w) begin
        if (is_digit) begin
          acc_w = (acc_w << 3) + (acc_w << 1) + {{(VAL_W-4){1'b0}}, ch[3:0]};
        end else begin
          invalid_w = 1'b1;
        end
      end
      adv.in_field    = in_field_w;
      adv.cur_numeric = numeric_w;
      adv.value_inv   = invalid_w;
      adv.value_acc   = acc_w;
    end

    res.line_done   = done;
    res.field_count = adv.fields_rec;

    // reset at end of line, else advance the saturating position
    if (done) begin
      st_nxt = STATE_RESET;
    end else begin
      st_nxt = adv;
      if (st.char_pos < POS_LAST) begin
        st_nxt.char_pos = st.char_pos + POS_W'(1);
      end
    end
  end

endmodule

// ----- rtl/command_line_field_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// command_line_field_tokenizer_core: streaming command line tokenizer
// Splits a character stream into numeric and alpha fields, one beat per char.
// ----------------------------------------------------------------------------
// Takes one character per beat and returns exactly one registered result beat
// for it. A new character can be taken every cycle while results drain: the
// tokenizer state and a single result register are updated in the cycle of
// acceptance, and in_ready stays high while the result register is empty or
// being drained by out_ready in the same cycle. A zero character ends the
// line, reports the field count and returns the line state to reset.
module command_line_field_tokenizer_core import clft_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_ch,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_char,
  output logic             out_field_start,
  output logic             out_start_type,
  output logic [IDX_W-1:0] out_start_index,
  output logic [POS_W-1:0] out_start_position,
  output logic             out_field_end,
  output logic [IDX_W-1:0] out_end_index,
  output logic [VAL_W-1:0] out_end_value,
  output logic             out_line_done,
  output logic [IDX_W-1:0] out_field_count
);

  clft_state_t  st_r;
  clft_state_t  st_nxt;
  clft_result_t res_nxt;
  clft_result_t res_r;
  logic         out_valid_r;
  logic         in_beat;

  assign in_ready = !out_valid_r || out_ready;
  assign in_beat  = in_valid && in_ready;

  // per-character logic
  clft_step u_step (
    .ch     (in_ch),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // hold line state; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (in_beat) begin
      st_r <= st_nxt;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_char           = res_r.out_char;
  assign out_field_start    = res_r.field_start;
  assign out_start_type     = res_r.start_type;
  assign out_start_index    = res_r.start_index;
  assign out_start_position = res_r.start_position;
  assign out_field_end      = res_r.field_end;
  assign out_end_index      = res_r.end_index;
  assign out_end_value      = res_r.end_value;
  assign out_line_done      = res_r.line_done;
  assign out_field_count    = res_r.field_count;

`ifndef ASSERT_OFF
  // an opened field is counted in the reported total
  a_start_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_start |-> out_start_index < out_field_count)
    else $error("opened field index not below field count");

  // a closed field was recorded earlier in the line
  a_end_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_end |-> out_end_index < out_field_count)
    else $error("closed field index not below field count");

  // end of line carries a zero character and opens nothing
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_done |-> out_char == 8'd0 && !out_field_start)
    else $error("line end beat carries a character or a field start");

  // end of line clears the field count and position
  a_eol_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_ch == CHAR_EOL |=> st_r.fields_rec == '0 && st_r.char_pos == '0)
    else $error("line state not cleared after end of line");
`endif

endmodule

// ----- tb/command_line_field_tokenizer_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_line_field_tokenizer_core_test: self-checking tokenizer testbench
// Streams directed and random command lines through the core with random
// sender bursts and receiver stalls, predicts every result beat in a
// scoreboard and compares it field by field in order of arrival.
// ----------------------------------------------------------------------------
module command_line_field_tokenizer_core_test import clft_pkg::*; ;

  localparam int        RANDOM_CHARS  = 1900;
  localparam int        QUIET_LIMIT   = 1000;
  localparam int        DRAIN_CYCLES  = 8;
  localparam int        HOLD_CYCLES   = 80;
  localparam int        HOLD_AFTER    = 300;
  localparam logic [VAL_W-1:0] ASCII_ZERO = VAL_W'(48);

  // Scoreboard: tracks the line state and holds the result beats still due
  class token_scoreboard;
    clft_state_t  line_st;
    clft_result_t due_results[$];
    int           errors;

    function new();
      line_st = STATE_RESET;
      errors  = 0;
    endfunction

    // Advance the line state by one accepted character and queue its result
    function void note_char(logic [7:0] ch);
      clft_result_t r;
      logic         digit;
      logic         letter;
      digit  = (ch > DIGIT_LO) && (ch < DIGIT_HI);
      letter = ((ch > UPPER_LO) && (ch < UPPER_HI)) || ((ch > LOWER_LO) && (ch < LOWER_HI));
      r = '0;
      if (!(digit || letter)) begin
        // delimiter or end of line closes a recorded field
        if (line_st.in_field) begin
          r.field_end = 1'b1;
          r.end_index = line_st.fields_rec - IDX_W'(1);
          r.end_value = (line_st.cur_numeric && !line_st.value_inv) ? line_st.value_acc : '0;
        end
        line_st.in_field    = 1'b0;
        line_st.after_delim = 1'b1;
        r.line_done = (ch == CHAR_EOL);
      end else begin
        r.out_char = ch;
        if (line_st.after_delim) begin
          line_st.after_delim = 1'b0;
          line_st.in_field    = 1'b0;
          // open a field only while slots remain
          if (line_st.fields_rec < FIELD_LIMIT) begin
            r.field_start    = 1'b1;
            r.start_type     = letter ? TYPE_ALPHA : TYPE_NUMERIC;
            r.start_index    = line_st.fields_rec;
            r.start_position = line_st.char_pos;
            line_st.fields_rec  = line_st.fields_rec + IDX_W'(1);
            line_st.in_field    = 1'b1;
            line_st.cur_numeric = digit;
            line_st.value_acc   = '0;
            line_st.value_inv   = 1'b0;
          end
        end
        // accumulate decimal value, a letter spoils a numeric field
        if (line_st.in_field && line_st.cur_numeric) begin
          if (digit) begin
            line_st.value_acc = line_st.value_acc * 10 + ({24'd0, ch} - ASCII_ZERO);
          end else begin
            line_st.value_inv = 1'b1;
          end
        end
      end
      r.field_count = line_st.fields_rec;
      if (r.line_done) begin
        line_st = STATE_RESET;
      end else if (line_st.char_pos != POS_LAST) begin
        line_st.char_pos = line_st.char_pos + POS_W'(1);
      end
      due_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: out_%s expected %0d, got %0d", $time, field, want, seen);
      end
    endfunction

    // Compare one accepted result beat with the oldest prediction
    function void check_beat(clft_result_t got);
      clft_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, out_char %0d", $time, got.out_char);
        return;
      end
      want = due_results.pop_front();
      compare_field("char",           VAL_W'(want.out_char),       VAL_W'(got.out_char));
      compare_field("field_start",    VAL_W'(want.field_start),    VAL_W'(got.field_start));
      compare_field("start_type",     VAL_W'(want.start_type),     VAL_W'(got.start_type));
      compare_field("start_index",    VAL_W'(want.start_index),    VAL_W'(got.start_index));
      compare_field("start_position", VAL_W'(want.start_position),
                    VAL_W'(got.start_position));
      compare_field("field_end",      VAL_W'(want.field_end),      VAL_W'(got.field_end));
      compare_field("end_index",      VAL_W'(want.end_index),      VAL_W'(got.end_index));
      compare_field("end_value",      want.end_value,              got.end_value);
      compare_field("line_done",      VAL_W'(want.line_done),      VAL_W'(got.line_done));
      compare_field("field_count",    VAL_W'(want.field_count),    VAL_W'(got.field_count));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_ch = 8'd0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_char;
  logic             out_field_start;
  logic             out_start_type;
  logic [IDX_W-1:0] out_start_index;
  logic [POS_W-1:0] out_start_position;
  logic             out_field_end;
  logic [IDX_W-1:0] out_end_index;
  logic [VAL_W-1:0] out_end_value;
  logic             out_line_done;
  logic [IDX_W-1:0] out_field_count;

  token_scoreboard board;
  logic [7:0]      char_stream[$];
  int              results_seen = 0;
  int              quiet_cycles = 0;

  command_line_field_tokenizer_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_ch              (in_ch),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char           (out_char),
    .out_field_start    (out_field_start),
    .out_start_type     (out_start_type),
    .out_start_index    (out_start_index),
    .out_start_position (out_start_position),
    .out_field_end      (out_field_end),
    .out_end_index      (out_end_index),
    .out_end_value      (out_end_value),
    .out_line_done      (out_line_done),
    .out_field_count    (out_field_count)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] rand_digit();
    return 8'd48 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) == 0) ? 8'd65 + 8'($urandom_range(0, 25))
                                       : 8'd97 + 8'($urandom_range(0, 25));
  endfunction

  // Any nonzero byte that is neither a letter nor a digit
  function automatic logic [7:0] rand_delim();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while ((c > DIGIT_LO && c < DIGIT_HI) || (c > UPPER_LO && c < UPPER_HI) ||
               (c > LOWER_LO && c < LOWER_HI));
    return c;
  endfunction

  // Append one random line: mostly well-formed fields, some noise, rare long lines
  function automatic void add_random_line();
    int  n_fields;
    int  flen;
    int  kind;
    int  lead;
    bit  long_line;
    long_line = ($urandom_range(0, 19) == 0);
    n_fields  = $urandom_range(0, 9);
    lead      = long_line ? $urandom_range(120, 140) : $urandom_range(0, 2);
    repeat (lead) char_stream.push_back(rand_delim());
    for (int f = 0; f < n_fields; f++) begin
      kind = $urandom_range(0, 9);
      flen = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
      for (int k = 0; k < flen; k++) begin
        if (kind < 5) begin
          char_stream.push_back(rand_digit());
        end else if (kind < 7) begin
          char_stream.push_back((k == 0 || $urandom_range(0, 3) != 0) ? rand_letter()
                                                                       : rand_digit());
        end else if (kind < 9) begin
          // numeric start with a stray letter
          char_stream.push_back((k == 0 || $urandom_range(0, 2) != 0) ? rand_digit()
                                                                       : rand_letter());
        end else begin
          char_stream.push_back(8'($urandom_range(1, 255)));
        end
      end
      if (f != n_fields - 1 || $urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 2)) char_stream.push_back(rand_delim());
      end
    end
    char_stream.push_back(CHAR_EOL);
  endfunction

  // Offer the stream in bursts of random length with random gaps between them
  task automatic send_stream();
    int burst;
    int gap;
    burst = 0;
    foreach (char_stream[i]) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      @(negedge clk);
      in_valid <= 1'b1;
      in_ch    <= char_stream[i];
      do @(posedge clk); while (!in_ready);
      burst--;
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Receiver: rotating stall mask, plus one long hold-off to fill the core
  initial begin
    int          pattern_age;
    int          hold_left;
    bit          held;
    logic [15:0] stall_mask;
    pattern_age = 0;
    hold_left   = 0;
    held        = 1'b0;
    stall_mask  = '1;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (pattern_age == 0) begin
          pattern_age = $urandom_range(32, 128);
          stall_mask  = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end
        out_ready  <= stall_mask[0];
        stall_mask = {stall_mask[0], stall_mask[15:1]};
        pattern_age--;
      end
    end
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    clft_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.note_char(in_ch);
      end
      if (out_valid && out_ready) begin
        got.out_char       = out_char;
        got.field_start    = out_field_start;
        got.start_type     = out_start_type;
        got.start_index    = out_start_index;
        got.start_position = out_start_position;
        got.field_end      = out_field_end;
        got.end_index      = out_end_index;
        got.end_value      = out_end_value;
        got.line_done      = out_line_done;
        got.field_count    = out_field_count;
        board.check_beat(got);
        results_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("command_line_field_tokenizer_core_test NOT OK");
    $finish;
  end

  initial begin
    string opening;
    board = new();
    // empty line, then a delimiter-only line with an all-ones byte
    char_stream.push_back(CHAR_EOL);
    char_stream.push_back(8'hFF);
    char_stream.push_back(8'd47);
    char_stream.push_back(CHAR_EOL);
    // class boundaries, letter in a numeric field, seventh field past the limit
    char_stream.push_back(8'd57);
    char_stream.push_back(8'd122);
    char_stream.push_back(8'h80);
    opening = "a0:0@Z[9`A{z";
    for (int k = 0; k < opening.len(); k++) char_stream.push_back(opening[k]);
    char_stream.push_back(CHAR_EOL);
    while (char_stream.size() < RANDOM_CHARS) add_random_line();

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    send_stream();
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("command_line_field_tokenizer_core_test OK");
    end else begin
      $display("command_line_field_tokenizer_core_test NOT OK");
    end
    $finish;
  end

endmodule
